// ===== sv/lottery_slot_picker_assert.svh =====
`ifndef LOTTERY_SLOT_PICKER_ASSERT_SVH
`define LOTTERY_SLOT_PICKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lsp_pkg.sv =====
package lsp_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_DRAW  = 1'b1
  } lsp_op_t;

  typedef struct packed {
    lsp_op_t     op;
    logic [5:0]  slot;
    logic [15:0] tickets;
    logic        eligible;
  } lsp_in_t;

  typedef struct packed {
    logic [5:0] chosen_slot;
    logic       found;
  } lsp_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_RAND,
    ST_MOD,
    ST_PICK,
    ST_RESULT
  } lsp_state_t;

  localparam logic [63:0] SEED_BASE = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] SEED_MUL  = 64'hbf58_476d_1ce4_e5b9;
  localparam int XS_SHL_A = 13;
  localparam int XS_SHR_B = 7;
  localparam int XS_SHL_C = 17;
  localparam int RAND_W   = 64;

  function automatic logic [63:0] seed_for(logic [2:0] cpu);
    logic [3:0]  c;
    logic [63:0] p;
    logic [63:0] s;
    c = {1'b0, cpu} + 4'd1;
    // the cpu factor is only four bits wide, so a few shifted adds
    p = '0;
    for (int k = 0; k < 4; k++) begin
      if (c[k]) begin
        p = p + (SEED_MUL << k);
      end
    end
    s = SEED_BASE ^ p;
    if (s == 64'd0) begin
      s = 64'd1;
    end
    return s;
  endfunction

  function automatic logic [63:0] xs_step(logic [63:0] s);
    logic [63:0] x;
    x = (s == 64'd0) ? 64'd1 : s;
    x = x ^ (x << XS_SHL_A);
    x = x ^ (x >> XS_SHR_B);
    x = x ^ (x << XS_SHL_C);
    return x;
  endfunction

endpackage

// ===== sv/lottery_slot_picker.sv =====
// write item: accepted with no result; the next item may follow at once
// draw item: passes through the sum scan, the seed step, the bit-serial modulo, the pick
// scan and the result step, which waits for a free output; an empty table skips to the result
// one draw at a time; in_ready is low from draw acceptance until its result is registered
// reset (synchronous, active low) clears the eligible bits by a pass over the ram with
// in_ready low, and seeds the generator for cpu 0
`include "lottery_slot_picker_assert.svh"

module lottery_slot_picker import lsp_pkg::*; #(
  parameter int SLOTS       = 64,
  parameter int TICKET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lsp_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lsp_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TOT_W  = TICKET_BITS + SLOT_W;
  localparam int WORD_W = TICKET_BITS + 1;
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);
  localparam logic [63:0] SEED_RESET = seed_for(3'd0);

  lsp_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;
  logic [SLOT_W-1:0]      pidx_r, pidx_nxt;
  logic [TOT_W-1:0]       acc_r, acc_nxt;
  logic [63:0]            rng_r, rng_nxt;
  logic [5:0]             res_slot_r, res_slot_nxt;
  logic                   res_found_r, res_found_nxt;
  logic                   out_valid_r;
  lsp_out_t               out_data_r;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WORD_W-1:0]      ram_rdata;
  logic [TICKET_BITS-1:0] tk_in;
  logic                   slot_ok;

  logic                   in_fire;
  logic                   scan_run;
  logic                   scan_end;
  logic                   hit;
  logic [TOT_W-1:0]       acc_add;
  logic                   win;
  logic                   out_free;
  logic                   mod_start;
  logic                   mod_done;
  logic [TOT_W-1:0]       draw;
  logic [63:0]            rng_step;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign scan_end = (cnt_r == CNT_END) && !pend_r;
  assign hit      = pend_r && ram_rdata[TICKET_BITS];
  assign acc_add  = acc_r + TOT_W'(ram_rdata[TICKET_BITS-1:0]);
  assign win      = hit && (acc_add > draw);
  assign rng_step = xs_step(rng_r);
  assign slot_ok  = 32'(in_data.slot) < SLOTS;

  always_comb begin
    tk_in = TICKET_BITS'(in_data.tickets);
    if (tk_in == '0) begin
      tk_in = TICKET_BITS'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && in_data.op == OP_DRAW) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (scan_end) state_nxt = (acc_r == '0) ? ST_RESULT : ST_RAND;
      end
      ST_RAND: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (mod_done) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (win || scan_end) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    scan_run  = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = SLOT_W'(in_data.slot);
    ram_wdata = {in_data.eligible, tk_in};
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[SLOT_W-1:0];
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_fire && in_data.op == OP_WRITE && slot_ok;
      end
      ST_SUM, ST_PICK: begin
        scan_run = 1'b1;
      end
      ST_RAND: begin
        mod_start = 1'b1;
      end
      ST_MOD, ST_RESULT: begin
        scan_run = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt       = cnt_r;
    pend_nxt      = scan_run && (cnt_r < CNT_END);
    pidx_nxt      = cnt_r[SLOT_W-1:0];
    acc_nxt       = acc_r;
    rng_nxt       = rng_r;
    res_slot_nxt  = res_slot_r;
    res_found_nxt = res_found_r;
    case (state_r)
      ST_CLEAR: cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + CNT_W'(1);
      ST_IDLE: begin
        cnt_nxt = '0;
        acc_nxt = '0;
      end
      ST_SUM, ST_PICK: begin
        if (cnt_r < CNT_END) cnt_nxt = cnt_r + CNT_W'(1);
        if (hit) acc_nxt = acc_add;
      end
      ST_RAND: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        rng_nxt = rng_step;
      end
      default: cnt_nxt = cnt_r;
    endcase
    // empty table or a scan that ran out reports nothing found
    if ((state_r == ST_SUM && scan_end && acc_r == '0)
        || (state_r == ST_PICK && scan_end && !win)) begin
      res_slot_nxt  = '0;
      res_found_nxt = 1'b0;
    end else if (state_r == ST_PICK && win) begin
      res_slot_nxt  = 6'(pidx_r);
      res_found_nxt = 1'b1;
    end
    if (cfg_valid && cfg_ready) begin
      rng_nxt = seed_for(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      rng_r       <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      rng_r   <= rng_nxt;
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    pidx_r      <= pidx_nxt;
    acc_r       <= acc_nxt;
    res_slot_r  <= res_slot_nxt;
    res_found_r <= res_found_nxt;
    if (state_r == ST_RESULT && out_free) begin
      out_data_r.chosen_slot <= res_slot_r;
      out_data_r.found       <= res_found_r;
    end
  end

  lsp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ticket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  lsp_mod_unit #(
    .DIV_W (TOT_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (rng_step),
    .divisor  (acc_r),
    .done     (mod_done),
    .rem      (draw)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LSP_ASSERT_NEXT(a_draw_starts_scan, in_valid && in_ready && in_data.op == OP_DRAW, state_r == ST_SUM, "draw item did not start the ticket scan")
  `LSP_ASSERT_NOW(a_out_from_result, $rose(out_valid_r), $past(state_r) == ST_RESULT, "result appeared outside the result step")
  `LSP_ASSERT_NOW(a_pick_below_draw, state_r == ST_PICK, acc_r <= draw, "running sum passed the draw without a pick")

endmodule

// ===== sv/lsp_ram.sv =====
module lsp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lsp_mod_unit.sv =====
`include "lottery_slot_picker_assert.svh"

module lsp_mod_unit import lsp_pkg::*; #(
  parameter int DIV_W = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  rem
);

  localparam int STEP_W = $clog2(RAND_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RAND_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [63:0]       quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  // restoring remainder, one dividend bit per cycle, msb first
  always_comb begin
    trial    = {rem_r, quo_r[63]};
    diff     = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = quo_r << 1;
      rem_nxt  = (trial >= {1'b0, div_r}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  `LSP_ASSERT_NOW(a_rem_below_div, busy_r && !start, rem_r < div_r, "remainder reached divisor")
  `LSP_ASSERT_NEXT(a_done_after_last, busy_r && !start && step_r == LAST_STEP, done_r && !busy_r, "modulo did not finish after last step")

endmodule

// ===== tb/lottery_slot_picker_tb.sv =====
module lottery_slot_picker_tb;
  import lsp_pkg::*;

  localparam int NSLOTS         = 64;
  localparam int PHASE_ITEMS    = 443;
  localparam int SETTLE_CYCLES  = 250;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    lsp_in_t  item;
    logic     typed;
    lsp_out_t want;
  } dir_row_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  lsp_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  lsp_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data  = 3'd0;

  // side info that travels with the item on the input channel
  logic     row_typed = 1'b0;
  lsp_out_t row_want  = '0;

  // scheduler state as predicted
  logic [63:0] rng_state;
  logic [15:0] slot_tickets [NSLOTS];
  logic        slot_elig    [NSLOTS];

  lsp_out_t picks_due [$];
  int       errors     = 0;
  int       quiet_cycles = 0;
  int       snd_idle   = 0;
  int       rcv_idle   = 0;
  int       density    = 50;
  logic     hold_req   = 1'b0;

  dir_row_t dir_rows [21];

  lottery_slot_picker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] golden_seed(input logic [2:0] cpu);
    logic [63:0] s;
    s = SEED_BASE ^ ((64'(cpu) + 64'd1) * SEED_MUL);
    return (s == 64'd0) ? 64'd1 : s;
  endfunction

  function automatic logic [63:0] xorshift_next(input logic [63:0] s);
    logic [63:0] x;
    x = (s == 64'd0) ? 64'd1 : s;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

  task automatic lottery_apply(input lsp_in_t it, output logic drew, output lsp_out_t pick);
    logic [63:0] total;
    logic [63:0] target;
    logic [63:0] running;
    drew    = 1'b0;
    pick    = '0;
    total   = '0;
    running = '0;
    if (it.op == OP_WRITE) begin
      slot_tickets[it.slot] = (it.tickets == 16'd0) ? 16'd1 : it.tickets;
      slot_elig[it.slot]    = it.eligible;
    end else begin
      drew = 1'b1;
      for (int i = 0; i < NSLOTS; i++) begin
        if (slot_elig[i]) total += 64'(slot_tickets[i]);
      end
      // an empty table leaves the generator untouched
      if (total != 64'd0) begin
        rng_state = xorshift_next(rng_state);
        target    = rng_state % total;
        for (int i = 0; i < NSLOTS && !pick.found; i++) begin
          if (slot_elig[i]) begin
            running += 64'(slot_tickets[i]);
            if (running > target) begin
              pick.chosen_slot = 6'(i);
              pick.found       = 1'b1;
            end
          end
        end
      end
    end
  endtask

  initial begin
    rng_state = golden_seed(3'd0);
    for (int i = 0; i < NSLOTS; i++) begin
      slot_tickets[i] = '0;
      slot_elig[i]    = 1'b0;
    end
  end

  // scoreboard, predictor update and watchdog
  always @(posedge clk) begin
    lsp_out_t want;
    lsp_out_t pick;
    logic     drew;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (picks_due.size() == 0) begin
          $error("unexpected result: chosen_slot=%0d found=%0d",
                 out_data.chosen_slot, out_data.found);
          errors++;
        end else begin
          want = picks_due.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_data.found);
            errors++;
          end
          if (out_data.chosen_slot !== want.chosen_slot) begin
            $error("chosen_slot: expected %0d, actual %0d",
                   want.chosen_slot, out_data.chosen_slot);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        lottery_apply(in_data, drew, pick);
        if (drew) picks_due.push_back(row_typed ? row_want : pick);
      end
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        rng_state = golden_seed(cfg_data);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_item(input lsp_in_t it, input logic typed, input lsp_out_t want);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_data   = it;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, let all draws come back, then give the block time to go idle
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (picks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cpu(input logic [2:0] cpu);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = cpu;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic lsp_in_t random_item();
    lsp_in_t it;
    it.op   = ($urandom_range(99) < 35) ? OP_DRAW : OP_WRITE;
    it.slot = 6'($urandom_range(63));
    case ($urandom_range(9))
      0:       it.tickets = 16'h0000;
      1:       it.tickets = 16'hffff;
      2, 3:    it.tickets = 16'($urandom_range(1, 4));
      default: it.tickets = 16'($urandom_range(16'hffff));
    endcase
    it.eligible = ($urandom_range(99) < density);
    return it;
  endfunction

  task automatic random_phase(input int sender_idle, input int receiver_idle,
                              input logic [2:0] cpu, input logic long_hold);
    quiesce();
    write_cpu(cpu);
    snd_idle = sender_idle;
    rcv_idle = receiver_idle;
    if (long_hold) hold_req = 1'b1;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // vary how crowded the table gets, from nearly empty to nearly full
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       density = 10;
          1:       density = 50;
          default: density = 90;
        endcase
      end
      send_item(random_item(), 1'b0, '0);
    end
  endtask

  initial begin
    dir_rows = '{
      // empty table right after reset
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b1, '{6'd0,  1'b0}},
      // zero tickets count as one
      '{'{OP_WRITE, 6'd0,  16'h0000, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b1, '{6'd0,  1'b1}},
      '{'{OP_WRITE, 6'd0,  16'hffff, 1'b0}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b1, '{6'd0,  1'b0}},
      // draw ignores the other fields
      '{'{OP_DRAW,  6'd63, 16'hffff, 1'b1}, 1'b1, '{6'd0,  1'b0}},
      '{'{OP_WRITE, 6'd63, 16'hffff, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b1, '{6'd63, 1'b1}},
      '{'{OP_WRITE, 6'd0,  16'h0001, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b0, '{6'd0,  1'b0}},
      // big totals
      '{'{OP_WRITE, 6'd1,  16'hffff, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_WRITE, 6'd31, 16'h8000, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_WRITE, 6'd32, 16'h5555, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_WRITE, 6'd62, 16'haaaa, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd21, 16'h1234, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_WRITE, 6'd63, 16'h0000, 1'b1}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b0, '{6'd0,  1'b0}},
      // ineligible write leaves the draw alone
      '{'{OP_WRITE, 6'd42, 16'h00ff, 1'b0}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b0, '{6'd0,  1'b0}},
      '{'{OP_DRAW,  6'd0,  16'h0000, 1'b0}, 1'b0, '{6'd0,  1'b0}}
    };

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    quiesce();
    write_cpu(3'd0);
    for (int r = 0; r < $size(dir_rows); r++) begin
      send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
    end

    random_phase(18, 86, 3'd7, 1'b0);
    random_phase(86, 18, 3'd3, 1'b0);
    random_phase(0, 0, 3'($urandom_range(1, 6)), 1'b1);

    quiesce();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== lottery_slot_picker.f =====
+incdir+sv
sv/lsp_pkg.sv
sv/lsp_ram.sv
sv/lsp_mod_unit.sv
sv/lottery_slot_picker.sv
tb/lottery_slot_picker_tb.sv
